/* hdl/mrdf_pkg.sv */
// Shared types and constants for the mesh receive duplicate filter.
// Holds the table entry layout, verdict and drop reason codes, CSR indexes.
// No dependencies.
`timescale 1ns / 1ps

package mrdf_pkg;

   localparam int TableEntriesDefault = 16;

   localparam logic [15:0] BcastAddr = 16'hffff;

   localparam int CsrIndexW = 4;
   localparam int CsrDataW  = 16;

   localparam logic [CsrIndexW-1:0] CSR_OWN_ADDRESS = 4'd0;
   localparam logic [CsrIndexW-1:0] CSR_TTL_RELOAD  = 4'd1;

   localparam logic [15:0] OwnAddressReset = 16'h0000;
   localparam logic [7:0]  TtlReloadReset  = 8'd10;

   typedef enum logic [1:0] {
      VERDICT_NONE   = 2'd0,
      VERDICT_DROP   = 2'd1,
      VERDICT_ACCEPT = 2'd2,
      VERDICT_ROUTE  = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      REASON_NONE      = 3'd0,
      REASON_OWN       = 3'd1,
      REASON_DUP       = 3'd2,
      REASON_FULL      = 3'd3,
      REASON_BCAST_ACK = 3'd4,
      REASON_NOT_ADDR  = 3'd5
   } reason_type;

   typedef struct packed {
      logic [15:0] source;
      logic [7:0]  sequence_num;
      logic [7:0]  lifetime;
   } entry_type;

endpackage

/* hdl/mrdf_table.sv */
// Per-source record memory: one write port, one registered read port.
// Valid bits make a never-written entry read as free. Uses mrdf_pkg.
`timescale 1ns / 1ps

module mrdf_table #(
   parameter int TABLE_ENTRIES = mrdf_pkg::TableEntriesDefault,
   parameter int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [IdxW-1:0]     rd_addr,
   output mrdf_pkg::entry_type rd_data,
   output logic                rd_live,
   input  logic                wr_en,
   input  logic [IdxW-1:0]     wr_addr,
   input  mrdf_pkg::entry_type wr_data
);
   import mrdf_pkg::*;

   entry_type               mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] vld_ff;
   entry_type               rd_data_ff;
   logic                    rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_live = rd_vld_ff && (rd_data_ff.lifetime != 8'd0);

endmodule

/* hdl/mrdf_ctrl.sv */
// Sequencer: scans the record table one entry a cycle, ages or updates it,
// and forms the verdict. Holds the CSRs. Uses mrdf_pkg, drives mrdf_table.
`timescale 1ns / 1ps

module mrdf_ctrl #(
   parameter int TABLE_ENTRIES = mrdf_pkg::TableEntriesDefault,
   parameter int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [15:0]                       req_source_address,
   input  logic [7:0]                        req_sequence_number,
   input  logic [15:0]                       req_network_destination,
   input  logic [15:0]                       req_link_destination,
   input  logic                              req_ack_requested,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_verdict,
   output logic [2:0]                        rsp_drop_reason,
   output logic                              rsp_rebroadcast,
   input  logic                              csr_valid,
   input  logic [mrdf_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [mrdf_pkg::CsrDataW-1:0]     csr_data,
   output logic                              rd_en,
   output logic [IdxW-1:0]                   rd_addr,
   input  mrdf_pkg::entry_type               rd_data,
   input  logic                              rd_live,
   output logic                              wr_en,
   output logic [IdxW-1:0]                   wr_addr,
   output mrdf_pkg::entry_type               wr_data
);
   import mrdf_pkg::*;

   localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] own_addr_ff, own_addr_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic        cmd_ff, cmd_in;
   logic [15:0] src_ff, src_in;
   logic [7:0]  seq_ff, seq_in;
   logic [15:0] ndst_ff, ndst_in;
   logic [15:0] ldst_ff, ldst_in;
   logic        ack_ff, ack_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic        issued_all_ff, issued_all_in;
   logic        pend_ff, pend_in;
   logic [IdxW-1:0] pend_idx_ff, pend_idx_in;
   logic        free_ff, free_in;
   logic [IdxW-1:0] free_idx_ff, free_idx_in;
   reason_type  tbl_reason_ff, tbl_reason_in;
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type verdict_ff, verdict_in;
   reason_type  reason_ff, reason_in;
   logic        rebro_ff, rebro_in;

   logic [7:0] seq_diff;
   logic       match;
   logic       is_new;
   logic       last;
   logic       free_now;
   logic [IdxW-1:0] free_idx_now;
   entry_type  new_entry;

   assign seq_diff  = seq_ff - rd_data.sequence_num;
   assign is_new    = (seq_diff != 8'd0) && !seq_diff[7];
   assign match     = pend_ff && rd_live && (rd_data.source == src_ff);
   assign last      = pend_ff && (pend_idx_ff == LastIdx);
   assign new_entry = '{source: src_ff, sequence_num: seq_ff, lifetime: ttl_ff};
   // the entry seen this cycle counts as the highest free one so far
   assign free_now     = free_ff || (pend_ff && !rd_live);
   assign free_idx_now = (pend_ff && !rd_live) ? pend_idx_ff : free_idx_ff;

   always_comb begin
      state_in      = state_ff;
      own_addr_in   = own_addr_ff;
      ttl_in        = ttl_ff;
      cmd_in        = cmd_ff;
      src_in        = src_ff;
      seq_in        = seq_ff;
      ndst_in       = ndst_ff;
      ldst_in       = ldst_ff;
      ack_in        = ack_ff;
      idx_in        = idx_ff;
      issued_all_in = issued_all_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      tbl_reason_in = tbl_reason_ff;
      rsp_valid_in  = 1'b0;
      verdict_in    = verdict_ff;
      reason_in     = reason_ff;
      rebro_in      = rebro_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = pend_idx_ff;
      wr_data       = rd_data;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS: own_addr_in = csr_data[15:0];
            CSR_TTL_RELOAD:  ttl_in      = csr_data[7:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in        = req_command;
               src_in        = req_source_address;
               seq_in        = req_sequence_number;
               ndst_in       = req_network_destination;
               ldst_in       = req_link_destination;
               ack_in        = req_ack_requested;
               idx_in        = '0;
               issued_all_in = 1'b0;
               free_in       = 1'b0;
               if (!req_command && (req_source_address == own_addr_ff)) begin
                  rsp_valid_in = 1'b1;
                  verdict_in   = VERDICT_DROP;
                  reason_in    = REASON_OWN;
                  rebro_in     = 1'b0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // issue one read a cycle, process its data the cycle after
            if (!issued_all_ff) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
               if (idx_ff == LastIdx) begin
                  issued_all_in = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end

            if (cmd_ff) begin
               if (pend_ff && rd_live) begin
                  wr_en            = 1'b1;
                  wr_data.lifetime = rd_data.lifetime - 8'd1;
               end
               if (last) begin
                  rsp_valid_in = 1'b1;
                  verdict_in   = VERDICT_NONE;
                  reason_in    = REASON_NONE;
                  rebro_in     = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else if (match) begin
               if (is_new) begin
                  wr_en         = 1'b1;
                  wr_data       = new_entry;
                  tbl_reason_in = REASON_NONE;
               end else begin
                  tbl_reason_in = REASON_DUP;
               end
               state_in = ST_DECIDE;
            end else begin
               free_in     = free_now;
               free_idx_in = free_idx_now;
               if (last) begin
                  if (free_now) begin
                     wr_en         = 1'b1;
                     wr_addr       = free_idx_now;
                     wr_data       = new_entry;
                     tbl_reason_in = REASON_NONE;
                  end else begin
                     tbl_reason_in = REASON_FULL;
                  end
                  state_in = ST_DECIDE;
               end
            end
         end

         ST_DECIDE: begin
            rsp_valid_in = 1'b1;
            rebro_in     = 1'b0;
            reason_in    = REASON_NONE;
            state_in     = ST_IDLE;
            if (tbl_reason_ff != REASON_NONE) begin
               verdict_in = VERDICT_DROP;
               reason_in  = tbl_reason_ff;
            end else if ((ndst_ff == BcastAddr) && ack_ff) begin
               verdict_in = VERDICT_DROP;
               reason_in  = REASON_BCAST_ACK;
            end else begin
               rebro_in = (ldst_ff == BcastAddr) && (ndst_ff != own_addr_ff);
               if ((ndst_ff == own_addr_ff) || (ndst_ff == BcastAddr)) begin
                  verdict_in = VERDICT_ACCEPT;
               end else if (ldst_ff == own_addr_ff) begin
                  verdict_in = VERDICT_ROUTE;
               end else begin
                  verdict_in = VERDICT_DROP;
                  reason_in  = REASON_NOT_ADDR;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         own_addr_ff  <= OwnAddressReset;
         ttl_ff       <= TtlReloadReset;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         own_addr_ff   <= own_addr_in;
         ttl_ff        <= ttl_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmd_ff        <= cmd_in;
         src_ff        <= src_in;
         seq_ff        <= seq_in;
         ndst_ff       <= ndst_in;
         ldst_ff       <= ldst_in;
         ack_ff        <= ack_in;
         idx_ff        <= idx_in;
         issued_all_ff <= issued_all_in;
         pend_idx_ff   <= pend_idx_in;
         free_ff       <= free_in;
         free_idx_ff   <= free_idx_in;
         tbl_reason_ff <= tbl_reason_in;
         verdict_ff    <= verdict_in;
         reason_ff     <= reason_in;
         rebro_ff      <= rebro_in;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_drop_reason = reason_ff;
   assign rsp_rebroadcast = rebro_ff;

endmodule

/* hdl/mesh_rx_duplicate_filter_unit.sv */
// Mesh receive duplicate filter, top level.
// Instantiates mrdf_ctrl and mrdf_table; uses mrdf_pkg.
//
// Usage:
//   Request: drive req_* and raise start; the item transfers at a clock edge
//   with start high and busy low. req_command 0 is a frame header, 1 an
//   aging tick.
//   Response: one result per item, shown on rsp_* for exactly one cycle while
//   rsp_valid is high. The receiver cannot stall, so it must take it then.
//   CSR: csr_valid/csr_ready write channel, index 0 own_address, index 1
//   ttl_reload; other indexes are ignored. csr_ready is always high; write
//   only while busy is low and no response is outstanding.
// Sequencing:
//   A frame from this node's own address answers in the cycle after transfer.
//   Every other item scans the record memory one entry per cycle through its
//   single registered read port; a tick answers at the end of the scan and a
//   frame adds a decision state, reached early when a live record matches.
//   Busy is low again in the cycle the response shows, so the next item can
//   follow at once.
// Reset:
//   Synchronous, active high. CSRs take their reset values and per-entry
//   valid bits clear, so every record is free; no clearing pass.
`timescale 1ns / 1ps

module mesh_rx_duplicate_filter_unit #(
   parameter int TABLE_ENTRIES = mrdf_pkg::TableEntriesDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_command,
   input  logic [15:0]                    req_source_address,
   input  logic [7:0]                     req_sequence_number,
   input  logic [15:0]                    req_network_destination,
   input  logic [15:0]                    req_link_destination,
   input  logic                           req_ack_requested,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_verdict,
   output logic [2:0]                     rsp_drop_reason,
   output logic                           rsp_rebroadcast,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mrdf_pkg::CsrIndexW-1:0] csr_index,
   input  logic [mrdf_pkg::CsrDataW-1:0]  csr_data
);
   import mrdf_pkg::*;

   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic            rd_en;
   logic [IdxW-1:0] rd_addr;
   entry_type       rd_data;
   logic            rd_live;
   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   entry_type       wr_data;

   // CSR writes must arrive only while idle (the user's duty, not enforced here); accept them unconditionally
   assign csr_ready = 1'b1;

   mrdf_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IdxW(IdxW)
   ) u_ctrl (
      .clock,
      .reset,
      .start,
      .busy,
      .req_command,
      .req_source_address,
      .req_sequence_number,
      .req_network_destination,
      .req_link_destination,
      .req_ack_requested,
      .rsp_valid,
      .rsp_verdict,
      .rsp_drop_reason,
      .rsp_rebroadcast,
      .csr_valid,
      .csr_index,
      .csr_data,
      .rd_en,
      .rd_addr,
      .rd_data,
      .rd_live,
      .wr_en,
      .wr_addr,
      .wr_data
   );

   mrdf_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IdxW(IdxW)
   ) u_table (
      .clock,
      .reset,
      .rd_en,
      .rd_addr,
      .rd_data,
      .rd_live,
      .wr_en,
      .wr_addr,
      .wr_data
   );

endmodule

/* hdl/mrdf_checker.sv */
// Port-level checks for mesh_rx_duplicate_filter_unit, bound to the top level.
// Uses mrdf_pkg for the verdict and reason codes.
`timescale 1ns / 1ps

module mrdf_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_verdict,
   input logic [2:0] rsp_drop_reason,
   input logic       rsp_rebroadcast
);
   import mrdf_pkg::*;

   // a transfer either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("transfer neither answered nor in progress");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while still busy");

   a_reason_only_on_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_verdict != VERDICT_DROP)) |-> (rsp_drop_reason == REASON_NONE))
      else $error("drop reason set without drop verdict");

   a_tick_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_verdict == VERDICT_NONE)) |-> !rsp_rebroadcast)
      else $error("rebroadcast on tick response");

   a_no_rsp_without_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(busy)) |-> $past(start))
      else $error("response without a transferred item");

endmodule

bind mesh_rx_duplicate_filter_unit mrdf_checker u_mrdf_checker (
   .clock,
   .reset,
   .start,
   .busy,
   .rsp_valid,
   .rsp_verdict,
   .rsp_drop_reason,
   .rsp_rebroadcast
);
